@@ rtl/core/alu32_pkg.sv @@
// ----------------------------------------------------------------------------
// alu32_pkg
// Opcodes, status codes and stage payload types of the 32-bit ALU.
// ----------------------------------------------------------------------------
package alu32_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned OpWidth    = 4;
  localparam int unsigned ShiftWidth = 6;

  // opcodes
  localparam logic [OpWidth-1:0] OP_ADD  = 4'd0;
  localparam logic [OpWidth-1:0] OP_SUB  = 4'd1;
  localparam logic [OpWidth-1:0] OP_SHR  = 4'd2;
  localparam logic [OpWidth-1:0] OP_SHL  = 4'd3;
  localparam logic [OpWidth-1:0] OP_AND  = 4'd4;
  localparam logic [OpWidth-1:0] OP_OR   = 4'd5;
  localparam logic [OpWidth-1:0] OP_NOT  = 4'd6;
  localparam logic [OpWidth-1:0] OP_XOR  = 4'd7;
  localparam logic [OpWidth-1:0] OP_NAND = 4'd8;
  localparam logic [OpWidth-1:0] OP_NOR  = 4'd9;
  localparam logic [OpWidth-1:0] OP_XNOR = 4'd10;
  localparam logic [OpWidth-1:0] OP_INC  = 4'd11;
  localparam logic [OpWidth-1:0] OP_DEC  = 4'd12;

  // status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BAD_SHIFT = 3'd3,
    ST_BAD_OP    = 3'd4
  } status_t;

  // first stage: operands prepared for the shared adder, logic value done
  typedef struct packed {
    logic [OpWidth-1:0]    op;
    logic [DataWidth-1:0]  a;
    logic [DataWidth-1:0]  addend;
    logic                  carry_in;
    logic [DataWidth-1:0]  logic_val;
    logic [ShiftWidth-1:0] sh;
  } prep_t;

  // second stage: raw value and status
  typedef struct packed {
    logic [DataWidth-1:0] val;
    status_t              status;
  } exec_t;

endpackage

@@ rtl/core/alu_32bit_with_error_flags_core.sv @@
// ----------------------------------------------------------------------------
// alu_32bit_with_error_flags_core
// Three-stage pipelined 32-bit ALU with a status code per operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_ready carries one operation per beat:
//   operation, operand_a, operand_b, shift_amount.
//   Output channel out_valid / out_ready carries result and status.
//   A beat is taken on a rising edge with valid and ready both high.
//   Throughput is one operation per cycle when not stalled; the stages are
//   operand prep and logic ops, then the 33-bit adder and the barrel
//   shifter, then the output register that zeroes the result on any
//   error status.
//   When the receiver holds out_ready low the stages fill one by one and
//   in_ready drops only when all three hold a beat; no beat is lost or
//   repeated. Each stage refills in the cycle its contents move on.
//   Synchronous reset empties the pipeline: out_valid goes low.
//   Status: 0 ok, 1 overflow, 2 underflow, 3 bad shift, 4 unknown opcode.
// ----------------------------------------------------------------------------
module alu_32bit_with_error_flags_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [5:0]  shift_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result,
  output logic [2:0]  status
);

  logic                    valid1;
  logic                    valid2;
  logic                    ready1;
  logic                    ready2;
  logic                    ready3;
  alu32_pkg::prep_t        prep;
  alu32_pkg::prep_t        prep_next;
  alu32_pkg::exec_t        exec;
  alu32_pkg::exec_t        exec_next;
  logic [alu32_pkg::DataWidth:0] sum;
  logic                    carry;
  logic [4:0]              shift_dist;

  // stage handshake: a stage loads when empty or when its beat moves on
  assign ready3   = !out_valid || out_ready;
  assign ready2   = !valid2 || ready3;
  assign ready1   = !valid1 || ready2;
  assign in_ready = ready1;

  // stage 1: adder operands and bitwise ops
  always_comb begin
    prep_next.op        = operation;
    prep_next.a         = operand_a;
    prep_next.sh        = shift_amount;
    prep_next.addend    = operand_b;
    prep_next.carry_in  = 1'b0;
    prep_next.logic_val = '0;
    case (operation)
      alu32_pkg::OP_SUB: begin
        prep_next.addend   = ~operand_b;
        prep_next.carry_in = 1'b1;
      end
      alu32_pkg::OP_INC: begin
        prep_next.addend   = '0;
        prep_next.carry_in = 1'b1;
      end
      alu32_pkg::OP_DEC: begin
        prep_next.addend = '1;
      end
      alu32_pkg::OP_AND:  prep_next.logic_val = operand_a & operand_b;
      alu32_pkg::OP_OR:   prep_next.logic_val = operand_a | operand_b;
      alu32_pkg::OP_NOT:  prep_next.logic_val = ~operand_a;
      alu32_pkg::OP_XOR:  prep_next.logic_val = operand_a ^ operand_b;
      alu32_pkg::OP_NAND: prep_next.logic_val = ~(operand_a & operand_b);
      alu32_pkg::OP_NOR:  prep_next.logic_val = ~(operand_a | operand_b);
      alu32_pkg::OP_XNOR: prep_next.logic_val = ~(operand_a ^ operand_b);
      default: begin
        prep_next.addend = operand_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ready1) begin
      valid1 <= in_valid;
    end
    if (ready1 && in_valid) begin
      prep <= prep_next;
    end
  end

  // stage 2: shared adder, shifter and status
  assign sum        = {1'b0, prep.a} + {1'b0, prep.addend}
                    + {{alu32_pkg::DataWidth{1'b0}}, prep.carry_in};
  assign carry      = sum[alu32_pkg::DataWidth];
  assign shift_dist = prep.sh[4:0];

  always_comb begin
    exec_next.val    = '0;
    exec_next.status = alu32_pkg::ST_OK;
    case (prep.op)
      alu32_pkg::OP_ADD, alu32_pkg::OP_INC: begin
        exec_next.val = sum[alu32_pkg::DataWidth-1:0];
        if (carry) exec_next.status = alu32_pkg::ST_OVERFLOW;
      end
      alu32_pkg::OP_SUB, alu32_pkg::OP_DEC: begin
        exec_next.val = sum[alu32_pkg::DataWidth-1:0];
        if (!carry) exec_next.status = alu32_pkg::ST_UNDERFLOW;
      end
      alu32_pkg::OP_SHR: begin
        exec_next.val = prep.a >> shift_dist;
        if (prep.sh[5]) begin
          exec_next.status = alu32_pkg::ST_BAD_SHIFT;
        end else if (shift_dist != 5'd0 && prep.a[alu32_pkg::DataWidth-1]) begin
          exec_next.status = alu32_pkg::ST_OVERFLOW;
        end
      end
      alu32_pkg::OP_SHL: begin
        exec_next.val = prep.a << shift_dist;
        if (prep.sh[5]) begin
          exec_next.status = alu32_pkg::ST_BAD_SHIFT;
        end else if (shift_dist != 5'd0 && prep.a[0]) begin
          exec_next.status = alu32_pkg::ST_OVERFLOW;
        end
      end
      alu32_pkg::OP_AND, alu32_pkg::OP_OR, alu32_pkg::OP_NOT,
      alu32_pkg::OP_XOR, alu32_pkg::OP_NAND, alu32_pkg::OP_NOR,
      alu32_pkg::OP_XNOR: begin
        exec_next.val = prep.logic_val;
      end
      default: begin
        exec_next.status = alu32_pkg::ST_BAD_OP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (ready2) begin
      valid2 <= valid1;
    end
    if (ready2 && valid1) begin
      exec <= exec_next;
    end
  end

  // stage 3: output register, result forced to zero on error
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready3) begin
      out_valid <= valid2;
    end
    if (ready3 && valid2) begin
      result <= (exec.status == alu32_pkg::ST_OK) ? exec.val : '0;
      status <= exec.status;
    end
  end

`ifndef SYNTH
  // an error status never carries a nonzero result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != alu32_pkg::ST_OK |-> result == '0)
    else $error("error beat with nonzero result");

  // input backpressure only when every stage holds a beat
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> valid1 && valid2 && out_valid)
    else $error("input stalled with a free stage");

  // reset empties the pipeline
  assert property (@(posedge clk)
    rst |=> !out_valid && !valid1 && !valid2)
    else $error("pipeline not empty after reset");

  // a beat in stage 2 that is blocked stays there unchanged
  assert property (@(posedge clk) disable iff (rst)
    valid2 && !ready3 |=> valid2 && $stable(exec))
    else $error("stage 2 beat lost under stall");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pipelined 32-bit ALU with status codes.
// Operations stream in over the valid/ready input channel. A predictor
// computes each expected result and status at the moment the beat is
// accepted. A checker compares every output beat, in order, against the
// oldest pending prediction. The run covers directed corner cases, random
// streams under several idle and stall mixes, and one long receiver
// hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  import alu32_pkg::*;

  localparam logic [OpWidth-1:0] OP_BAD_LO = 4'd13;
  localparam logic [OpWidth-1:0] OP_BAD_HI = 4'd15;
  localparam int unsigned MAX_SHIFT      = 31;
  localparam int          PHASE_ITEMS    = 470;
  localparam int          PRESSURE_ITEMS = 40;
  localparam int          HOLD_CYCLES    = 60;
  localparam int          DRAIN_CYCLES   = 12;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    status_t              code;
  } alu_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OpWidth-1:0]    operation = '0;
  logic [DataWidth-1:0]  operand_a = '0;
  logic [DataWidth-1:0]  operand_b = '0;
  logic [ShiftWidth-1:0] shift_amount = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DataWidth-1:0]  result;
  logic [2:0]            status;

  alu_res_t pending_results[$];
  int       error_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     hold_req = 1'b0;
  int       quiet_cycles = 0;

  alu_32bit_with_error_flags_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .shift_amount (shift_amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result),
    .status       (status)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // expected value and status of one operation
  function automatic alu_res_t alu_predict(input logic [OpWidth-1:0] op,
                                           input logic [DataWidth-1:0] a,
                                           input logic [DataWidth-1:0] b,
                                           input logic [ShiftWidth-1:0] sh);
    alu_res_t           r;
    logic [DataWidth:0] sum;
    r.value = '0;
    r.code  = ST_OK;
    case (op)
      OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r.value = sum[DataWidth-1:0];
        if (sum[DataWidth]) r.code = ST_OVERFLOW;
      end
      OP_SUB: begin
        r.value = a - b;
        if (a < b) r.code = ST_UNDERFLOW;
      end
      OP_SHR: begin
        // range check wins over the lost-bit check
        if (sh > MAX_SHIFT) begin
          r.code = ST_BAD_SHIFT;
        end else begin
          r.value = a >> sh;
          if (sh != 0 && a[DataWidth-1]) r.code = ST_OVERFLOW;
        end
      end
      OP_SHL: begin
        if (sh > MAX_SHIFT) begin
          r.code = ST_BAD_SHIFT;
        end else begin
          r.value = a << sh;
          if (sh != 0 && a[0]) r.code = ST_OVERFLOW;
        end
      end
      OP_AND:  r.value = a & b;
      OP_OR:   r.value = a | b;
      OP_NOT:  r.value = ~a;
      OP_XOR:  r.value = a ^ b;
      OP_NAND: r.value = ~(a & b);
      OP_NOR:  r.value = ~(a | b);
      OP_XNOR: r.value = ~(a ^ b);
      OP_INC: begin
        r.value = a + 1;
        if (&a) r.code = ST_OVERFLOW;
      end
      OP_DEC: begin
        r.value = a - 1;
        if (a == '0) r.code = ST_UNDERFLOW;
      end
      default: r.code = ST_BAD_OP;
    endcase
    // any error clears the value
    if (r.code != ST_OK) r.value = '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataWidth-1:0] got,
                                 input logic [DataWidth-1:0] want);
    $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // one input beat, with random idle cycles ahead of it
  task automatic send_op(input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] a,
                         input logic [DataWidth-1:0] b, input logic [ShiftWidth-1:0] sh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      operation <= OpWidth'($urandom);
      operand_a <= $urandom;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    operand_a    <= a;
    operand_b    <= b;
    shift_amount <= sh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(alu_predict(op, a, b, sh));
  endtask

  // operand values biased toward carry, borrow and edge patterns
  function automatic logic [DataWidth-1:0] pick_word();
    logic [DataWidth-1:0] w;
    case ($urandom_range(7))
      0:       w = '0;
      1:       w = '1;
      2:       w = 32'h1 << $urandom_range(31);
      3:       w = ~(32'h1 << $urandom_range(31));
      4:       w = $urandom_range(15);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic run_random_ops(input int count);
    logic [OpWidth-1:0]    op;
    logic [ShiftWidth-1:0] sh;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) op = OpWidth'($urandom_range(OP_BAD_HI, OP_BAD_LO));
      else op = OpWidth'($urandom_range(OP_DEC));
      case ($urandom_range(7))
        0:       sh = '0;
        1:       sh = ShiftWidth'($urandom_range(63, 32));
        default: sh = ShiftWidth'($urandom_range(MAX_SHIFT));
      endcase
      send_op(op, pick_word(), pick_word(), sh);
    end
  endtask

  // corner cases of every opcode
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(OP_ADD, 32'h0, 32'h0, 6'd0);
    send_op(OP_ADD, 32'hFFFF_FFFF, 32'h1, 6'd63);
    send_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
    send_op(OP_SUB, 32'd5, 32'd3, 6'd0);
    send_op(OP_SUB, 32'd3, 32'd5, 6'd17);
    send_op(OP_SUB, 32'h0, 32'hFFFF_FFFF, 6'd0);
    send_op(OP_SHR, 32'h8000_0000, 32'h0, 6'd1);
    send_op(OP_SHR, 32'h8000_0001, 32'hFFFF_FFFF, 6'd0);
    send_op(OP_SHR, 32'h7FFF_FFFF, 32'h0, 6'd31);
    send_op(OP_SHR, 32'hFFFF_FFFF, 32'h0, 6'd32);
    send_op(OP_SHL, 32'h1, 32'h0, 6'd1);
    send_op(OP_SHL, 32'h1, 32'h0, 6'd0);
    send_op(OP_SHL, 32'hFFFF_FFFE, 32'h0, 6'd31);
    send_op(OP_SHL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_op(OP_AND, 32'hA5A5_A5A5, 32'h0F0F_0F0F, 6'd40);
    send_op(OP_OR, 32'hA5A5_A5A5, 32'h0F0F_0F0F, 6'd0);
    send_op(OP_NOT, 32'h0000_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_op(OP_XOR, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 6'd0);
    send_op(OP_NAND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
    send_op(OP_NOR, 32'h0, 32'h0, 6'd0);
    send_op(OP_XNOR, 32'h1234_5678, 32'h1234_5678, 6'd0);
    send_op(OP_INC, 32'hFFFF_FFFF, 32'h1, 6'd5);
    send_op(OP_DEC, 32'h0, 32'hFFFF_FFFF, 6'd63);
    send_op(OP_BAD_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
    send_op(OP_BAD_HI, 32'h1, 32'h2, 6'd3);
  endtask

  task automatic test_streaming();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_ops(PHASE_ITEMS);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 60;
    recv_stall_pct = 0;
    run_random_ops(PHASE_ITEMS);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    run_random_ops(PHASE_ITEMS);
  endtask

  task automatic test_mixed_idle();
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    run_random_ops(PHASE_ITEMS);
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= !hold_req;
    run_random_ops(PRESSURE_ITEMS);
  endtask

  // receiver ready, with random stalls and the counted hold-off
  initial begin : receiver
    int   remaining;
    logic hold_seen;
    remaining = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      // a toggle of hold_req starts one hold-off
      if (hold_req != hold_seen) begin
        remaining = HOLD_CYCLES;
        hold_seen = hold_req;
      end
      if (remaining > 0) begin
        remaining--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin : check_results
    alu_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, result", result, '0);
      end else begin
        want = pending_results.pop_front();
        if (result !== want.value) report_mismatch("result", result, want.value);
        if (status !== want.code) begin
          report_mismatch("status", DataWidth'(status), DataWidth'(want.code));
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_streaming();
    test_backpressure();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    recv_stall_pct = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
